@@ hdl/palette_dither_quantizer_assert.svh @@
// Assertion macros for the palette dither quantizer.
// Used by the top level only; no other dependencies.
`ifndef PALETTE_DITHER_QUANTIZER_ASSERT_SVH
`define PALETTE_DITHER_QUANTIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define PDQ_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PDQ_ASSERT(lbl, prop, msg) `PDQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define PDQ_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define PDQ_ASSERT(lbl, prop, msg)
`endif
`endif

@@ hdl/pdq_pkg.sv @@
// Shared types, constants and helper functions for the palette dither quantizer.
// No dependencies.
`default_nettype none
package pdq_pkg;
  localparam int unsigned ErrW  = 9;
  localparam int unsigned SumW  = 11;
  localparam int unsigned DistW = 18;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgAddrW-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_PALETTE_COUNT = 2'd2;

  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_PIXEL   = 1'b1;

  localparam logic [3:0] SHARE_RIGHT = 4'd7;
  localparam logic [3:0] SHARE_DOWN  = 4'd5;
  localparam logic [3:0] SHARE_LEFT  = 4'd3;
  localparam logic [3:0] SHARE_DIAG  = 4'd1;

  typedef logic signed [ErrW-1:0] err_t;
  typedef struct packed {
    err_t r;
    err_t g;
    err_t b;
  } err3_t;
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic accept_pal;
    logic accept_pix;
    logic lat_x;
    logic rd_xm1;
    logic lat_xm1;
    logic search_start;
    logic shares;
    logic wr_x;
    logic wr_xm1;
    logic out_load;
    logic clr_step;
  } pdq_cmd_t;

  typedef struct packed {
    logic search_done;
    logic clr_last;
    logic out_free;
    logic frame_end;
  } pdq_stat_t;

  // e*k/16, truncated toward zero
  function automatic err_t share(input err_t e, input logic [3:0] k);
    logic signed [13:0] ek;
    logic signed [13:0] pr;
    ek = {{5{e[ErrW-1]}}, e};
    pr = ek * $signed({10'd0, k});
    if (pr < 0) begin
      pr = pr + 14'sd15;
    end
    return err_t'(pr >>> 4);
  endfunction

  function automatic logic [7:0] sat8(input logic signed [SumW-1:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 11'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

@@ hdl/pdq_ctrl.sv @@
// Sequencer for the palette dither quantizer: steps each pixel through
// read, search, diffusion and output. Depends on pdq_pkg.
`default_nettype none
module pdq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  input  wire logic              opcode_i,
  output logic                   s_axis_tready,
  input  wire pdq_pkg::pdq_stat_t stat_i,
  output pdq_pkg::pdq_cmd_t      cmd_o
);
  import pdq_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD1  = 4'd2;
  localparam logic [3:0] S_RD2  = 4'd3;
  localparam logic [3:0] S_SRCH = 4'd4;
  localparam logic [3:0] S_ERR  = 4'd5;
  localparam logic [3:0] S_WR0  = 4'd6;
  localparam logic [3:0] S_WR1  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_PIXEL) begin
            cmd_o.accept_pix = 1'b1;
            state_d = S_RD1;
          end else begin
            cmd_o.accept_pal = 1'b1;
          end
        end
      end
      S_RD1: begin
        cmd_o.lat_x  = 1'b1;
        cmd_o.rd_xm1 = 1'b1;
        state_d = S_RD2;
      end
      S_RD2: begin
        cmd_o.lat_xm1      = 1'b1;
        cmd_o.search_start = 1'b1;
        state_d = S_SRCH;
      end
      S_SRCH: begin
        if (stat_i.search_done) state_d = S_ERR;
      end
      S_ERR: begin
        cmd_o.shares = 1'b1;
        state_d = S_WR0;
      end
      S_WR0: begin
        cmd_o.wr_x = 1'b1;
        state_d = S_WR1;
      end
      S_WR1: begin
        cmd_o.wr_xm1 = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the result
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = stat_i.frame_end ? S_CLR : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

@@ hdl/pdq_datapath.sv @@
// Datapath of the palette dither quantizer: config registers, palette and
// error-row memories, nearest-color search pipeline, diffusion and output.
// Depends on pdq_pkg.
`default_nettype none
module pdq_datapath #(
  parameter int unsigned MAX_WIDTH     = 1024,
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pdq_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  wire logic [pdq_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic [7:0]                     entry_i,
  input  wire pdq_pkg::rgb_t                  rgb_i,
  input  wire pdq_pkg::pdq_cmd_t              cmd_i,
  output pdq_pkg::pdq_stat_t                  stat_o,
  input  wire logic                           m_axis_tready,
  output logic                                m_axis_tvalid,
  output logic [7:0]                          m_axis_tdata,
  output logic                                m_axis_tlast
);
  import pdq_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PA = $clog2(PALETTE_DEPTH);

  // configuration
  logic [10:0] fw_q;
  logic [15:0] fh_q;
  logic [8:0]  pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= 11'd1024;
      fh_q <= 16'd1024;
      pc_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_FRAME_WIDTH:   fw_q <= cfg_data_i[10:0];
        REG_FRAME_HEIGHT:  fh_q <= cfg_data_i;
        REG_PALETTE_COUNT: pc_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] w_eff;
  logic [15:0]   h_eff;
  logic [8:0]    n_eff;

  always_comb begin
    if (fw_q == 11'd0) begin
      w_eff = CW'(1);
    end else if (32'(fw_q) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(fw_q);
    end
    h_eff = (fh_q == 16'd0) ? 16'd1 : fh_q;
    if (pc_q == 9'd0) begin
      n_eff = 9'd1;
    end else if (32'(pc_q) > PALETTE_DEPTH) begin
      n_eff = 9'(PALETTE_DEPTH);
    end else begin
      n_eff = pc_q;
    end
  end

  // position
  logic [CW-1:0] col_q;
  logic [15:0]   row_q;
  logic          last_col, last_row;
  logic [CW-1:0] x;
  logic [AW-1:0] x_a, xm1_a;

  assign last_col = (col_q >= w_eff - CW'(1));
  assign last_row = (row_q >= h_eff - 16'd1);
  assign x        = last_col ? (w_eff - CW'(1)) : col_q;
  assign x_a      = AW'(x);
  assign xm1_a    = x_a - AW'(1);

  // palette store
  rgb_t           pal_mem [PALETTE_DEPTH];
  logic [8:0]     srch_cnt_q;
  logic           srch_act_q;
  rgb_t           pal_rd_q;
  logic           p1_vld_q;
  logic [PA-1:0]  p1_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_pal && (32'(entry_i) < PALETTE_DEPTH)) begin
      pal_mem[entry_i[PA-1:0]] <= rgb_i;
    end
    pal_rd_q <= pal_mem[srch_cnt_q[PA-1:0]];
  end

  // error-row store
  err3_t          nre_mem [MAX_WIDTH];
  logic [AW-1:0]  nre_addr;
  logic           nre_we;
  err3_t          nre_wd;
  err3_t          nre_rd_q;
  logic [AW-1:0]  clr_cnt_q;

  err3_t nre_x_q, nre_xm1_q, rc_q, diag_q, diag_use;
  err3_t s7_q, s5_q, s3_q, s1_q;

  assign diag_use = (x_a == AW'(0)) ? '0 : diag_q;

  always_comb begin
    nre_addr = x_a;
    nre_we   = 1'b0;
    nre_wd   = '0;
    if (cmd_i.clr_step) begin
      nre_addr = clr_cnt_q;
      nre_we   = 1'b1;
    end else if (cmd_i.rd_xm1) begin
      nre_addr = xm1_a;
    end else if (cmd_i.wr_x) begin
      nre_we = 1'b1;
      if (!last_row) begin
        nre_wd.r = diag_use.r + s5_q.r;
        nre_wd.g = diag_use.g + s5_q.g;
        nre_wd.b = diag_use.b + s5_q.b;
      end
    end else if (cmd_i.wr_xm1) begin
      nre_addr = xm1_a;
      nre_we   = (x_a != AW'(0)) && !last_row;
      nre_wd.r = nre_xm1_q.r + s3_q.r;
      nre_wd.g = nre_xm1_q.g + s3_q.g;
      nre_wd.b = nre_xm1_q.b + s3_q.b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nre_we) nre_mem[nre_addr] <= nre_wd;
    nre_rd_q <= nre_mem[nre_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= stat_o.clr_last ? '0 : clr_cnt_q + AW'(1);
    end
  end

  // pixel correction
  rgb_t in_q, pix_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_pix) in_q <= rgb_i;
    if (cmd_i.lat_x) nre_x_q <= nre_rd_q;
    if (cmd_i.lat_xm1) nre_xm1_q <= nre_rd_q;
    if (cmd_i.search_start) begin
      pix_q.r <= sat8(SumW'($signed({3'd0, in_q.r})) + SumW'(nre_x_q.r) + SumW'(rc_q.r));
      pix_q.g <= sat8(SumW'($signed({3'd0, in_q.g})) + SumW'(nre_x_q.g) + SumW'(rc_q.g));
      pix_q.b <= sat8(SumW'($signed({3'd0, in_q.b})) + SumW'(nre_x_q.b) + SumW'(rc_q.b));
    end
  end

  // search pipeline: read, squares, accumulate-compare
  logic [15:0]      sq_r_q, sq_g_q, sq_b_q;
  rgb_t             p2_rgb_q;
  logic [PA-1:0]    p2_idx_q;
  logic             p2_vld_q;
  logic [DistW-1:0] bestd_q, dist_sum;
  logic [PA-1:0]    best_q;
  rgb_t             best_rgb_q;
  logic signed [ErrW-1:0]   dr, dg, db;
  logic signed [2*ErrW-1:0] pr, pg, pb;

  assign dr = $signed({1'b0, pal_rd_q.r}) - $signed({1'b0, pix_q.r});
  assign dg = $signed({1'b0, pal_rd_q.g}) - $signed({1'b0, pix_q.g});
  assign db = $signed({1'b0, pal_rd_q.b}) - $signed({1'b0, pix_q.b});
  assign pr = dr * dr;
  assign pg = dg * dg;
  assign pb = db * db;
  assign dist_sum = DistW'(sq_r_q) + DistW'(sq_g_q) + DistW'(sq_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srch_act_q <= 1'b0;
      srch_cnt_q <= '0;
      p1_vld_q   <= 1'b0;
      p2_vld_q   <= 1'b0;
    end else begin
      if (cmd_i.search_start) begin
        srch_act_q <= 1'b1;
        srch_cnt_q <= '0;
      end else if (srch_act_q) begin
        if (srch_cnt_q == n_eff - 9'd1) begin
          srch_act_q <= 1'b0;
          srch_cnt_q <= '0;
        end else begin
          srch_cnt_q <= srch_cnt_q + 9'd1;
        end
      end
      p1_vld_q <= srch_act_q;
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_idx_q <= srch_cnt_q[PA-1:0];
    sq_r_q   <= pr[15:0];
    sq_g_q   <= pg[15:0];
    sq_b_q   <= pb[15:0];
    p2_rgb_q <= pal_rd_q;
    p2_idx_q <= p1_idx_q;
    if (cmd_i.search_start) begin
      bestd_q <= '1;
      best_q  <= '0;
    end else if (p2_vld_q && (dist_sum < bestd_q)) begin
      bestd_q    <= dist_sum;
      best_q     <= p2_idx_q;
      best_rgb_q <= p2_rgb_q;
    end
  end

  // error diffusion terms
  err3_t err;
  assign err = '{r: $signed({1'b0, pix_q.r}) - $signed({1'b0, best_rgb_q.r}),
                 g: $signed({1'b0, pix_q.g}) - $signed({1'b0, best_rgb_q.g}),
                 b: $signed({1'b0, pix_q.b}) - $signed({1'b0, best_rgb_q.b})};

  always_ff @(posedge clk_i) begin
    if (cmd_i.shares) begin
      s7_q <= '{share(err.r, SHARE_RIGHT), share(err.g, SHARE_RIGHT), share(err.b, SHARE_RIGHT)};
      s5_q <= '{share(err.r, SHARE_DOWN), share(err.g, SHARE_DOWN), share(err.b, SHARE_DOWN)};
      s3_q <= '{share(err.r, SHARE_LEFT), share(err.g, SHARE_LEFT), share(err.b, SHARE_LEFT)};
      s1_q <= '{share(err.r, SHARE_DIAG), share(err.g, SHARE_DIAG), share(err.b, SHARE_DIAG)};
    end
  end

  // carries, positions and output register
  logic out_vld_q, out_last_q;
  logic [7:0] out_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q      <= '0;
      diag_q    <= '0;
      col_q     <= '0;
      row_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.wr_x) begin
        rc_q   <= last_col ? '0 : s7_q;
        diag_q <= last_col ? '0 : s1_q;
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? 16'd0 : row_q + 16'd1;
        end else begin
          col_q <= x + CW'(1);
        end
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_idx_q  <= 8'(best_q);
      out_last_q <= last_col && last_row;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_idx_q;
  assign m_axis_tlast  = out_last_q;

  assign stat_o = '{search_done: !srch_act_q && !p1_vld_q && !p2_vld_q,
                    clr_last:    (clr_cnt_q == AW'(MAX_WIDTH - 1)),
                    out_free:    !out_vld_q || m_axis_tready,
                    frame_end:   last_col && last_row};
endmodule
`default_nettype wire

@@ hdl/palette_dither_quantizer.sv @@
// Top level of the palette dither quantizer: joins sequencer and datapath.
// Depends on pdq_pkg, pdq_ctrl, pdq_datapath, palette_dither_quantizer_assert.svh.
//
//   port group   dir  payload
//   s_axis       in   tuser: opcode; tdata: entry_index, red, green, blue
//   m_axis       out  tdata: palette_index; tlast: frame_end
//   cfg          in   write enable, register index, data
//
// A palette write is taken in the idle state. A pixel is taken only when
// the previous one has reached the output register, and its nearest-color
// search reads one palette entry per cycle from a single read port. After
// reset and after each frame's last pixel the error row memory is cleared
// with the input held off. A finished result waits in the output register
// while the next request is accepted.
`default_nettype none
module palette_dither_quantizer #(
  parameter int unsigned MAX_WIDTH     = 1024,
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [pdq_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [pdq_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [31:0]                  s_axis_tdata,  // entry_index, red, green, blue
  input  wire logic                         s_axis_tuser,  // opcode
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // palette_index
  output logic                              m_axis_tlast
);
  import pdq_pkg::*;

  pdq_cmd_t  cmd;
  pdq_stat_t stat;
  rgb_t      rgb;

  assign rgb = '{r: s_axis_tdata[15:8], g: s_axis_tdata[23:16], b: s_axis_tdata[31:24]};

  pdq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .opcode_i      (s_axis_tuser),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  pdq_datapath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .entry_i       (s_axis_tdata[7:0]),
    .rgb_i         (rgb),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`include "palette_dither_quantizer_assert.svh"

  `PDQ_ASSERT(a_no_req_in_clear, cmd.clr_step |-> !s_axis_tready, "request taken during clear")
  `PDQ_ASSERT(a_load_when_free, cmd.out_load |-> (!m_axis_tvalid || m_axis_tready), "result overwritten")
  `PDQ_ASSERT(a_search_runs, cmd.search_start |=> !stat.search_done, "search did not start")
  `PDQ_ASSERT(a_clear_after_frame, (cmd.out_load && stat.frame_end) |=> cmd.clr_step, "no clear after frame")
endmodule
`default_nettype wire

@@ verif/palette_dither_quantizer_test.sv @@
// Self-checking bench for the palette dither quantizer: palette loads and
// dithered pixels are predicted in the bench and compared on the output stream.
// Depends on pdq_pkg and the palette_dither_quantizer RTL.
`default_nettype none
module palette_dither_quantizer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pdq_pkg::*;

  localparam int MaxW = 1024;
  localparam int PalD = 256;

  typedef struct packed {
    logic       op;
    logic [7:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } req_t;

  typedef struct packed {
    logic [7:0] index;
    logic       last;
  } pick_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // entry_index, red, green, blue
  logic s_axis_tuser = 1'b0;       // opcode
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // palette_index
  logic m_axis_tlast;

  palette_dither_quantizer DUT (.*);

  always #6 clk_i = ~clk_i;

  // bench copy of the block state
  logic [23:0] pal_mem [PalD];
  int row_err [MaxW][3];
  int carry_err [3];
  int diag_err [3];
  int col_pos, row_pos;
  int width_reg = 1024, height_reg = 1024, count_reg = 256;

  req_t  pending_reqs [$];
  pick_t expected_picks [$];
  int errors = 0;
  bit quiet = 1'b0;
  int hold_off = 0;
  bit sent_all = 1'b0;

  function automatic int share16(int e, int k);
    return (e * k) / 16;
  endfunction

  function automatic void predict(req_t q);
    int w, h, n, x, best, bestd, d, c;
    int pix [3];
    int err [3];
    int ch [3];
    bit lc, lr;
    pick_t pk;
    if (q.op == OP_PALETTE) begin
      pal_mem[q.idx] = {q.r, q.g, q.b};
      return;
    end
    w = (width_reg < 1) ? 1 : (width_reg > MaxW ? MaxW : width_reg);
    h = (height_reg < 1) ? 1 : height_reg;
    n = (count_reg < 1) ? 1 : (count_reg > PalD ? PalD : count_reg);
    x = (col_pos >= w) ? w - 1 : col_pos;
    lc = col_pos >= w - 1;
    lr = row_pos >= h - 1;
    ch[0] = q.r; ch[1] = q.g; ch[2] = q.b;
    for (c = 0; c < 3; c++) begin
      pix[c] = ch[c] + row_err[x][c] + carry_err[c];
      if (pix[c] < 0) pix[c] = 0;
      if (pix[c] > 255) pix[c] = 255;
    end
    best = 0;
    bestd = 32'h7fffffff;
    for (int i = 0; i < n; i++) begin
      d = (int'(pal_mem[i][23:16]) - pix[0]) ** 2 + (int'(pal_mem[i][15:8]) - pix[1]) ** 2
        + (int'(pal_mem[i][7:0]) - pix[2]) ** 2;
      if (d < bestd) begin
        bestd = d;
        best = i;
      end
    end
    err[0] = pix[0] - int'(pal_mem[best][23:16]);
    err[1] = pix[1] - int'(pal_mem[best][15:8]);
    err[2] = pix[2] - int'(pal_mem[best][7:0]);
    for (c = 0; c < 3; c++) begin
      if (x == 0) diag_err[c] = 0;
      if (lr) begin
        row_err[x][c] = 0;
      end else begin
        if (x > 0) row_err[x-1][c] += share16(err[c], 3);
        row_err[x][c] = diag_err[c] + share16(err[c], 5);
      end
      diag_err[c] = lc ? 0 : share16(err[c], 1);
      carry_err[c] = lc ? 0 : share16(err[c], 7);
    end
    pk.index = best[7:0];
    pk.last = lc && lr;
    expected_picks = {expected_picks, pk};
    if (lc) begin
      col_pos = 0;
      if (lr) begin
        row_pos = 0;
        foreach (row_err[i]) row_err[i] = '{0, 0, 0};
        carry_err = '{0, 0, 0};
        diag_err = '{0, 0, 0};
      end else begin
        row_pos = (row_pos + 1) & 16'hffff;
      end
    end else begin
      col_pos = x + 1;
    end
  endfunction

  // driver
  int gap = 0;
  req_t cur;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict(cur);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap > 0) begin
          gap <= gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= cur.op;
          s_axis_tdata <= {cur.b, cur.g, cur.r, cur.idx};
          if (!quiet && $urandom_range(0, 5) == 0) gap <= $urandom_range(1, 7);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int stall = 0;
  pick_t want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_picks.size() == 0) begin
          $display("%0t unexpected result: actual index %0d last %0b", $time,
                   m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          want = expected_picks.pop_front();
          if (m_axis_tdata !== want.index || m_axis_tlast !== want.last) begin
            $display("%0t mismatch: expected index %0d last %0b, actual index %0d last %0b",
                     $time, want.index, want.last, m_axis_tdata, m_axis_tlast);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else if (stall > 0) begin
        stall <= stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) stall <= $urandom_range(1, 7);
      end
    end
  end

  function automatic void add_req(req_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic req_t pal_req(int i, int r, int g, int b);
    return '{op: OP_PALETTE, idx: i[7:0], r: r[7:0], g: g[7:0], b: b[7:0]};
  endfunction

  function automatic req_t pix_req(int r, int g, int b);
    return '{op: OP_PIXEL, idx: 8'($urandom()), r: r[7:0], g: g[7:0], b: b[7:0]};
  endfunction

  task automatic drain();
    int guard;
    guard = 0;
    while ((pending_reqs.size() > 0 || s_axis_tvalid || expected_picks.size() > 0)
           && guard < 2000000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (MaxW + 300) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] a, int v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= a;
    cfg_data_i <= v[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (a == REG_FRAME_WIDTH) width_reg = v & 16'h7ff;
    else if (a == REG_FRAME_HEIGHT) height_reg = v & 16'hffff;
    else count_reg = v & 16'h1ff;
  endtask

  task automatic setup(int w, int h, int n);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_PALETTE_COUNT, n);
  endtask

  // random phase: mostly pixels, some palette rewrites inside the written range
  task automatic random_phase(int items, int pal_hi);
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(0, 15) == 0)
        add_req(pal_req($urandom_range(0, pal_hi), $urandom, $urandom, $urandom));
      else if ($urandom_range(0, 9) == 0)
        add_req(pix_req($urandom_range(0, 1) * 255,
                        $urandom_range(0, 1) * 255,
                        $urandom_range(0, 1) * 255));
      else
        add_req(pix_req($urandom, $urandom, $urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (MaxW + 20) @(posedge clk_i);
    // fill every entry so any count is safe
    for (int i = 0; i < PalD; i++)
      add_req(pal_req(i, $urandom, $urandom, $urandom));
    add_req(pal_req(0, 0, 0, 0));
    add_req(pal_req(1, 255, 255, 255));
    add_req(pal_req(2, 255, 0, 0));
    add_req(pal_req(3, 255, 0, 0));  // tie with entry 2
    drain();
    setup(3, 2, 4);
    add_req(pix_req(0, 0, 0));
    add_req(pix_req(255, 255, 255));
    add_req(pix_req(250, 10, 5));
    add_req(pix_req(128, 128, 128));
    add_req(pix_req(200, 200, 200));
    add_req(pix_req(60, 60, 60));
    add_req(pix_req(127, 127, 127));
    drain();
    // out-of-range settings saturate
    setup(0, 0, 0);
    add_req(pix_req(100, 50, 25));
    add_req(pix_req(255, 0, 255));
    drain();
    setup(2047, 1, 511);
    random_phase(40, 255);
    drain();
    // long receiver hold-off while the sender keeps offering
    setup(5, 4, 16);
    hold_off = 400;
    random_phase(300, 15);
    drain();
    setup(1, 65535, 2);
    random_phase(200, 1);
    drain();
    setup(7, 3, 256);
    random_phase(150, 255);
    drain();
    setup(1024, 2, 1);
    random_phase(200, 0);
    drain();
    setup(4, 5, 32);
    random_phase(200, 31);
    drain();
    quiet = 1'b1;
    setup(6, 3, 8);
    random_phase(150, 7);
    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(60ms);
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+hdl
hdl/pdq_pkg.sv
hdl/pdq_ctrl.sv
hdl/pdq_datapath.sv
hdl/palette_dither_quantizer.sv
verif/palette_dither_quantizer_test.sv
